// ===== sv/frm_pkg.sv =====
// Shared types and constants of the frame rate meter with stall alarm.
// Used by frm_hist and the top level; depends on nothing else.
package frm_pkg;

  // Fixed field widths.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned DEN_W  = WIN_W + 1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_RATE_EN  = 2'd0;
  localparam logic [1:0] REG_ALARM_EN = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;
  localparam logic [1:0] REG_INTERVAL = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [WIN_W-1:0] WINDOW_RST   = 16'd2000;
  localparam logic [WIN_W-1:0] INTERVAL_RST = 16'd1000;

  // Event kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Rounded rate is (RATE_SCALE*n + diff) / (2*diff).
  localparam logic [10:0] RATE_SCALE = 11'd2000;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  // Frame push request into the history buffer.
  typedef struct packed {
    logic              push;
    logic [TIME_W-1:0] time_ms;
  } push_t;

endpackage

// ===== sv/frm_hist.sv =====
// Frame time history: a circular buffer in a memory that behaves as a shift line.
// Uses frm_pkg for the push request type and the time width.
module frm_hist #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  frm_pkg::push_t                  push,
  input  logic [IW-1:0]                   rd_idx,
  output logic [frm_pkg::TIME_W-1:0]      head_time,
  output logic [frm_pkg::TIME_W-1:0]      rd_data
);

  logic [frm_pkg::TIME_W-1:0] mem [DEPTH];
  logic [IW-1:0]              head;
  logic [IW-1:0]              head_next;
  logic [IW:0]                fill;
  logic [IW:0]                fill_next;
  logic [frm_pkg::TIME_W-1:0] head_q;
  logic [IW:0]                addr_sum;
  logic [IW-1:0]              rd_addr;
  logic [frm_pkg::TIME_W-1:0] rd_raw;
  logic                       rd_live;

  // A nonempty head moves the head back one slot, which ages every entry by one.
  always_comb begin
    head_next = head;
    fill_next = fill;
    if (head_q != '0) begin
      head_next = (head == '0) ? IW'(DEPTH - 1) : head - 1'b1;
      fill_next = (fill == (IW+1)'(DEPTH)) ? fill : fill + 1'b1;
    end else if (fill == '0) begin
      fill_next = (IW+1)'(1);
    end
  end

  // Logical index to physical slot, wrapping once around the buffer.
  always_comb begin
    addr_sum = {1'b0, head} + {1'b0, rd_idx};
    rd_addr  = (addr_sum >= (IW+1)'(DEPTH)) ? IW'(addr_sum - (IW+1)'(DEPTH))
                                            : addr_sum[IW-1:0];
  end

  // Head pointer, fill count and a copy of the newest entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      fill   <= '0;
      head_q <= '0;
    end else if (push.push) begin
      head   <= head_next;
      fill   <= fill_next;
      head_q <= push.time_ms;
    end
  end

  // Memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[head_next] <= push.time_ms;
    end
    rd_raw  <= mem[rd_addr];
    rd_live <= ({1'b0, rd_idx} < fill);
  end

  // Slots never written read as empty.
  assign rd_data   = rd_live ? rd_raw : '0;
  assign head_time = head_q;

endmodule

// ===== sv/frm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone unit; depends on no package.
module frm_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // Bring down the next numerator bit and try a subtract.
  always_comb begin
    rem_sh = {rem, quo_r[NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den});
  end

  // Control: busy until all NUM_W quotient bits are formed, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator register fills up with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem   <= '0;
    end else if (busy) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem   <= ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    end
  end

  assign quo = quo_r;

endmodule

// ===== sv/frame_rate_meter_with_stall_alarm.sv =====
// Top level of the frame rate meter with stall alarm: sequencer, registers, output stage.
// Depends on frm_pkg, frm_hist and frm_div.
//
// Usage: the input channel (in_valid, in_stall, kind, time_ms) carries one event
// per beat, a frame arrival or a process tick, with its time in milliseconds.
// Every input beat gives exactly one output beat (out_valid, out_stall, rate,
// rate_valid, alarm_raised, alarm_changed). Frames enter a history buffer of
// HISTORY_DEPTH entries; a tick updates the no-frame alarm if enabled and, when the
// report interval has run out and reports are enabled, counts recent frames and divides.
// A frame, or a tick without a report, goes from accept straight to the finish
// state. A reporting tick scans the history one entry per cycle through the
// memory read port, then runs the bit-serial divider. One event is in work at
// a time; in_stall is high from accept until the result has moved into the
// output register. When the receiver stalls, the result holds in the output
// register and the block waits. Reset clears the history, alarm and report
// time and loads the register defaults. The user must write the configuration
// port only while the block is idle; the block itself does not enforce this.
module frame_rate_meter_with_stall_alarm #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [frm_pkg::TIME_W-1:0]   time_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [frm_pkg::RATE_W-1:0]   rate,
  output logic                         rate_valid,
  output logic                         alarm_raised,
  output logic                         alarm_changed,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [frm_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned IW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned NUM_W = ((IW + 11 > 16) ? IW + 11 : 16) + 1;
  localparam int unsigned DEN_W = frm_pkg::DEN_W;

  frm_pkg::state_t state;
  frm_pkg::state_t state_next;

  // Configuration registers.
  logic                      rate_en;
  logic                      alarm_en;
  logic [frm_pkg::WIN_W-1:0] window;
  logic [frm_pkg::WIN_W-1:0] interval;

  // Tick state.
  logic [frm_pkg::TIME_W-1:0] last_report;
  logic [frm_pkg::TIME_W-1:0] latest_seen;
  logic                       alarm_state;
  logic [frm_pkg::TIME_W-1:0] now_r;

  // Scan state.
  logic [IW-1:0]              scan_idx;
  logic [IW-1:0]              chk_idx;
  logic                       chk_pend;
  logic [IW-1:0]              n_cnt;
  logic [frm_pkg::WIN_W-1:0]  diff_r;

  // Pending result.
  logic [frm_pkg::RATE_W-1:0] res_rate;
  logic                       res_rv;
  logic                       res_chg;

  // Handshake and control.
  logic                       in_acc;
  logic                       out_free;
  logic                       load_out;
  logic                       div_start;
  logic                       div_done;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic [NUM_W-1:0]           div_quo;

  // History interface.
  frm_pkg::push_t             push;
  logic [frm_pkg::TIME_W-1:0] head_time;
  logic [frm_pkg::TIME_W-1:0] rd_data;

  // Per-entry and per-tick decisions.
  logic [frm_pkg::TIME_W-1:0] age;
  logic                       hit;
  logic                       last_idx;
  logic                       stalled;
  logic                       due;
  logic                       has_div;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign push.push    = in_acc && (kind == frm_pkg::KIND_FRAME);
  assign push.time_ms = time_ms;

  frm_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rd_idx   (scan_idx),
    .head_time(head_time),
    .rd_data  (rd_data)
  );

  // The entry under check counts when it is nonempty and inside the window.
  always_comb begin
    age      = now_r - rd_data;
    hit      = (rd_data != '0) && (age <= {16'b0, window});
    last_idx = (chk_idx == IW'(HISTORY_DEPTH - 2));
    stalled  = (latest_seen == head_time);
    due      = ((time_ms - last_report) > {16'b0, interval});
    has_div  = (n_cnt != '0) && (diff_r != '0);
  end

  // Dividend and divisor of the rounded rate.
  assign div_num = NUM_W'(n_cnt) * NUM_W'(frm_pkg::RATE_SCALE) + NUM_W'(diff_r);
  assign div_den = {diff_r, 1'b0};

  frm_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      frm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (kind == frm_pkg::KIND_TICK && due && rate_en) begin
            state_next = frm_pkg::ST_SCAN;
          end else begin
            state_next = frm_pkg::ST_FIN;
          end
        end
      end
      frm_pkg::ST_SCAN: begin
        if (chk_pend && (!hit || last_idx)) begin
          state_next = frm_pkg::ST_PREP;
        end
      end
      frm_pkg::ST_PREP: begin
        state_next = has_div ? frm_pkg::ST_DIV : frm_pkg::ST_FIN;
      end
      frm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = frm_pkg::ST_FIN;
        end
      end
      frm_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = frm_pkg::ST_IDLE;
        end
      end
      default: state_next = frm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = (state != frm_pkg::ST_IDLE);
    div_start = (state == frm_pkg::ST_PREP) && has_div;
    load_out  = (state == frm_pkg::ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the list do nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_en  <= 1'b0;
      alarm_en <= 1'b0;
      window   <= frm_pkg::WINDOW_RST;
      interval <= frm_pkg::INTERVAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        frm_pkg::REG_RATE_EN:  rate_en  <= cfg_data[0];
        frm_pkg::REG_ALARM_EN: alarm_en <= cfg_data[0];
        frm_pkg::REG_WINDOW:   window   <= cfg_data;
        frm_pkg::REG_INTERVAL: interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick bookkeeping: alarm, report time and the head seen at this tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_state <= 1'b0;
      last_report <= '0;
      latest_seen <= '0;
    end else if (in_acc && kind == frm_pkg::KIND_TICK) begin
      if (alarm_en) begin
        if (stalled && !alarm_state) begin
          alarm_state <= 1'b1;
        end else if (!stalled && alarm_state) begin
          alarm_state <= 1'b0;
        end
      end
      if (due) begin
        last_report <= time_ms;
      end
      latest_seen <= head_time;
    end
  end

  // Result fields set on accept and finished by the scan and the divider.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r    <= time_ms;
      res_rate <= '0;
      res_rv   <= (kind == frm_pkg::KIND_TICK) && due && rate_en;
      res_chg  <= (kind == frm_pkg::KIND_TICK) && alarm_en && (stalled != alarm_state);
    end else if (state == frm_pkg::ST_PREP && !has_div) begin
      res_rate <= frm_pkg::RATE_W'(n_cnt);
    end else if (state == frm_pkg::ST_DIV && div_done) begin
      res_rate <= (|div_quo[NUM_W-1:frm_pkg::RATE_W]) ? '1 : div_quo[frm_pkg::RATE_W-1:0];
    end
  end

  // History scan: issue one read per cycle, check the entry read the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_pend <= 1'b0;
    end else if (in_acc) begin
      chk_pend <= 1'b0;
    end else if (state == frm_pkg::ST_SCAN) begin
      chk_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      scan_idx <= IW'(1);
      n_cnt    <= '0;
      diff_r   <= '0;
    end else if (state == frm_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      chk_idx  <= scan_idx;
      if (chk_pend && hit) begin
        n_cnt  <= n_cnt + 1'b1;
        diff_r <= age[frm_pkg::WIN_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rate          <= res_rate;
      rate_valid    <= res_rv;
      alarm_raised  <= alarm_state;
      alarm_changed <= res_chg;
    end
  end

  // A result without a report carries a zero rate.
  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rate_valid |-> rate == '0)
    else $error("rate nonzero without a report");

  // The alarm moves only on the edge that accepts a tick.
  a_alarm_on_tick: assert property (@(posedge clk) disable iff (rst)
    alarm_state != $past(alarm_state) |-> $past(in_acc && kind == frm_pkg::KIND_TICK))
    else $error("alarm changed without a tick");

  // The scan never checks past the last counted index.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == frm_pkg::ST_SCAN && chk_pend |-> chk_idx <= IW'(HISTORY_DEPTH - 2))
    else $error("history scan ran past its end");

  // A new output beat is loaded only from the finish state.
  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == frm_pkg::ST_FIN))
    else $error("output loaded outside the finish state");

endmodule
